>>> sv/isqrt_pkg.sv
// ----------------------------------------------------------------------------
// isqrt_pkg
// Shared types and constants for the binary-search integer square root core.
// ----------------------------------------------------------------------------
package isqrt_pkg;

  // width of the result word
  localparam int ROOT_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_SQUARE,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture radicand
    logic seed;    // set search bounds from leading-zero count
    logic square;  // register mid * mid
    logic update;  // narrow the interval
    logic finish;  // load result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;    // interval closed (upper < lower)
  } status_t;

endpackage

>>> sv/isqrt_in_if.sv
// ----------------------------------------------------------------------------
// isqrt_in_if
// Valid/ready channel carrying one radicand word.
// ----------------------------------------------------------------------------
interface isqrt_in_if #(
  parameter int RADICAND_WIDTH = 32
);
  logic                      valid;
  logic                      ready;
  logic [RADICAND_WIDTH-1:0] radicand;

  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

>>> sv/isqrt_out_if.sv
// ----------------------------------------------------------------------------
// isqrt_out_if
// Valid/ready channel carrying one root word.
// ----------------------------------------------------------------------------
interface isqrt_out_if;
  logic                          valid;
  logic                          ready;
  logic [isqrt_pkg::ROOT_W-1:0]  root;

  modport source (output valid, output root, input ready);
  modport sink   (input valid, input root, output ready);
endinterface

>>> sv/isqrt_binary_search_core.sv
// Sequence: a seed step, then search rounds (square, then narrow), then a
//   closing check and the output load, which waits until the output
//   register is free.
// Throughput: one word per search; the next radicand waits until the
//   previous root is loaded.
// Reset: synchronous rst clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
// isqrt_binary_search_core
// Floor square root of an unsigned radicand by binary search over the root.
// ----------------------------------------------------------------------------
//
// Flow per word:
//   IDLE    take the radicand into the datapath.
//   SEED    find the leading one, set upper bound b = 2^k - 1 and lower
//           probe a = 2^(k-1) + 1 with k = ceil(significant bits / 2);
//           a zero radicand seeds an empty interval that yields 0.
//   SQUARE  if b < a the search is over, else register mid * mid.
//   UPDATE  compare the square with the radicand, move a or b past the
//           midpoint and form the next midpoint.
//   FINISH  load a - 1 into the output register when it is free.
//
// Round count is data dependent: at most k - 1 rounds for a radicand with
// 2k significant bits. The squarer (ceil(W/2) bits square) and the wide
// compare sit in separate cycles, so a round spans a SQUARE and an UPDATE state.
module isqrt_binary_search_core #(
  parameter int RADICAND_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  isqrt_in_if.sink      req,
  isqrt_out_if.source   rsp
);

  isqrt_pkg::cmd_t    cmd;
  isqrt_pkg::status_t status;

  // sequencer: owns handshake and output valid flag
  isqrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // bounds, squarer, result word register
  isqrt_datapath #(
    .RADICAND_WIDTH (RADICAND_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .radicand (req.radicand),
    .cmd      (cmd),
    .status   (status),
    .root     (rsp.root)
  );

endmodule

>>> sv/isqrt_datapath.sv
// ----------------------------------------------------------------------------
// isqrt_datapath
// Bound registers, midpoint squarer and compare for the binary search.
// ----------------------------------------------------------------------------
module isqrt_datapath #(
  parameter int RADICAND_WIDTH = 32
) (
  input  logic                          clk,
  input  logic [RADICAND_WIDTH-1:0]     radicand,
  input  isqrt_pkg::cmd_t               cmd,
  output isqrt_pkg::status_t            status,
  output logic [isqrt_pkg::ROOT_W-1:0]  root
);

  localparam int W  = RADICAND_WIDTH;
  localparam int HW = (W + 1) / 2;          // root width
  localparam int AW = HW + 1;               // lower bound may reach 2^HW
  localparam int SW = AW + 1;               // bound sums
  localparam int PW = 2 * HW;               // square width
  localparam int KW = $clog2(W + 2);        // msb index / seed exponent
  localparam int EW = (AW > isqrt_pkg::ROOT_W) ? AW : isqrt_pkg::ROOT_W;

  logic [W-1:0]  x;
  logic [AW-1:0] a;
  logic [AW-1:0] b;
  logic [HW-1:0] m;
  logic [PW-1:0] prod;

  logic          found;
  logic [KW-1:0] msb;
  logic [KW-1:0] k;
  logic [AW-1:0] a_seed;
  logic [AW-1:0] b_seed;
  logic [SW-1:0] sum_seed;

  logic          gt;
  logic [AW-1:0] m_ext;
  logic [AW-1:0] a_upd;
  logic [AW-1:0] b_upd;
  logic [SW-1:0] sum_upd;
  logic [EW-1:0] res;

  // seed: b = 2^k - 1, a = 2^(k-1) + 1, k = ceil(sig bits / 2).
  // k never exceeds HW, so the cap at 2^HW - 1 is implied by the width.
  // zero radicand seeds a = 1, b = 0 so the search closes at once on 0.
  always_comb begin
    msb   = '0;
    found = |x;
    for (int i = 0; i < W; i++) begin
      if (x[i]) begin
        msb = KW'(i);
      end
    end
    k = KW'((msb + KW'(2)) >> 1);
    for (int i = 0; i < AW; i++) begin
      b_seed[i] = (KW'(i) < k);
    end
    a_seed = (AW'(1) << (k - KW'(1))) + AW'(1);
    if (!found) begin
      a_seed = AW'(1);
      b_seed = '0;
    end
    sum_seed = SW'(a_seed) + SW'(b_seed);
  end

  // interval update from the registered square
  always_comb begin
    gt    = prod > PW'(x);
    m_ext = AW'(m);
    if (gt) begin
      a_upd   = a;
      b_upd   = m_ext - AW'(1);
      sum_upd = SW'(a) + SW'(m_ext) - SW'(1);
    end else begin
      a_upd   = m_ext + AW'(1);
      b_upd   = b;
      sum_upd = SW'(m_ext) + SW'(1) + SW'(b);
    end
    res = EW'(a - AW'(1));
  end

  assign status.done = (b < a);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= radicand;
    end
    if (cmd.seed) begin
      a <= a_seed;
      b <= b_seed;
      m <= sum_seed[HW:1];
    end
    if (cmd.square) begin
      prod <= PW'(m) * PW'(m);
    end
    if (cmd.update) begin
      a <= a_upd;
      b <= b_upd;
      m <= sum_upd[HW:1];
    end
    if (cmd.finish) begin
      root <= res[isqrt_pkg::ROOT_W-1:0];
    end
  end

endmodule

>>> sv/isqrt_ctrl.sv
// ----------------------------------------------------------------------------
// isqrt_ctrl
// Sequencer for the square root search and the output word register flag.
// ----------------------------------------------------------------------------
module isqrt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  isqrt_pkg::status_t  status,
  output isqrt_pkg::cmd_t     cmd
);

  isqrt_pkg::state_t state;
  isqrt_pkg::state_t state_next;
  logic              out_valid_next;
  logic              slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= isqrt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      isqrt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = isqrt_pkg::ST_SEED;
        end
      end
      isqrt_pkg::ST_SEED: begin
        state_next = isqrt_pkg::ST_SQUARE;
      end
      isqrt_pkg::ST_SQUARE: begin
        if (status.done) begin
          state_next = isqrt_pkg::ST_FINISH;
        end else begin
          state_next = isqrt_pkg::ST_UPDATE;
        end
      end
      isqrt_pkg::ST_UPDATE: begin
        state_next = isqrt_pkg::ST_SQUARE;
      end
      isqrt_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_next = isqrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = isqrt_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      isqrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      isqrt_pkg::ST_SEED: begin
        cmd.seed = 1'b1;
      end
      isqrt_pkg::ST_SQUARE: begin
        cmd.square = !status.done;
      end
      isqrt_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      isqrt_pkg::ST_FINISH: begin
        if (slot_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
